>>> src/gdd_pkg.sv
package gdd_pkg;

    // Years above this are saturated before any use.
    localparam logic [13:0] MAX_YEAR = 14'd9999;

    // Division by 25 as a multiply by 1311 and a right shift by 15.
    // This is exact for dividends below about 4700, and the widest here is 2524.
    localparam logic [10:0] DIV25_MUL   = 11'd1311;
    localparam int          DIV25_SHIFT = 15;
    localparam logic [4:0]  TWENTY_FIVE = 5'd25;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    // Days in the whole months before the given month. Month zero has none before it.
    // Any month above twelve has all twelve before it.
    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] n;
        case (month)
            4'd0:    n = 9'd0;
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd365;
        endcase
        return n;
    endfunction

endpackage

>>> src/gdd_day_number.sv
module gdd_day_number
    import gdd_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  date_t       date,
    output logic [21:0] day_num
);

    // The first stage forms the quotient products, the scaled year and the day of year.
    logic [11:0] c_reg;
    logic [11:0] w4_reg;
    logic [22:0] pc_reg;
    logic [22:0] pa_reg;
    logic [22:0] pb_reg;
    logic [21:0] yr365_reg;
    logic [8:0]  doy_reg;
    logic        late_reg;
    logic        low2_reg;
    logic [21:0] num_reg;

    logic [11:0] c_next;
    logic [11:0] a_next;
    logic [9:0]  b_next;
    logic [11:0] w4_next;
    logic [14:0] y99;
    logic [14:0] y399;
    logic [14:0] y3;

    logic [6:0]  q100;
    logic [6:0]  qa;
    logic [6:0]  qb;
    logic [11:0] rem_base;
    logic        leap;
    logic [11:0] leaps;
    logic [21:0] num_next;

    always_comb
    begin
        y99     = 15'(date.year) + 15'd99;
        y399    = 15'(date.year) + 15'd399;
        y3      = 15'(date.year) + 15'd3;
        c_next  = date.year[13:2];
        a_next  = y99[13:2];
        b_next  = y399[13:4];
        w4_next = y3[13:2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg     <= c_next;
            w4_reg    <= w4_next;
            pc_reg    <= 23'(c_next) * 23'(DIV25_MUL);
            pa_reg    <= 23'(a_next) * 23'(DIV25_MUL);
            pb_reg    <= 23'(b_next) * 23'(DIV25_MUL);
            yr365_reg <= 22'(date.year) * 22'(YEAR_DAYS);
            doy_reg   <= days_before(date.month) + 9'(date.day);
            late_reg  <= (date.month >= 4'd3);
            low2_reg  <= (date.year[1:0] == 2'b00);
        end
    end

    // The second stage finishes the leap rule and sums the day number.
    always_comb
    begin
        q100     = pc_reg[DIV25_SHIFT +: 7];
        qa       = pa_reg[DIV25_SHIFT +: 7];
        qb       = pb_reg[DIV25_SHIFT +: 7];
        rem_base = 12'(q100) * 12'(TWENTY_FIVE);
        // A year divisible by 100 is a leap year only when its century count divides by 4.
        leap     = low2_reg && ((c_reg != rem_base) || (q100[1:0] == 2'b00));
        leaps    = w4_reg - 12'(qa) + 12'(qb);
        num_next = yr365_reg + 22'(leaps) + 22'(doy_reg) + 22'(late_reg && leap);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
        end
    end

    assign day_num = num_reg;

endmodule

>>> src/gregorian_date_difference_core.sv
// Channel   Direction  tdata (lowest bit up)                              tuser
// s_axis    in         start_day 5, start_month 4, start_year 14,         -
//                      end_day 5, end_month 4, end_year 14, pad 2
// m_axis    out        day_count 22, pad 2                                not_earlier
//
// A word can enter on every cycle while no result waits at the output, and it passes
// through four register stages: clamp, quotient products, day numbers, and the
// difference in the output register.
// Reset clears only the valid bits of the stages.
// When a result waits at the output, the whole pipeline holds. No word is lost or repeated.
module gregorian_date_difference_core
    import gdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // start_day, start_month, start_year, end_day,
                                        // end_month, end_year, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // day_count, zero pad
    output logic        m_axis_tuser    // not_earlier
);

    logic        adv;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        out_valid_reg;

    date_t       in_start;
    date_t       in_end;
    date_t       start1_reg;
    date_t       end1_reg;
    logic        earlier2_reg;
    logic        earlier3_reg;
    logic [21:0] start_num;
    logic [21:0] end_num;
    logic [22:0] diff;
    logic [21:0] count_next;
    logic        flag_next;
    logic [21:0] count_reg;
    logic        flag_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        in_start.day   = s_axis_tdata[4:0];
        in_start.month = s_axis_tdata[8:5];
        in_start.year  = (s_axis_tdata[22:9] > MAX_YEAR) ? MAX_YEAR : s_axis_tdata[22:9];
        in_end.day     = s_axis_tdata[27:23];
        in_end.month   = s_axis_tdata[31:28];
        in_end.year    = (s_axis_tdata[45:32] > MAX_YEAR) ? MAX_YEAR : s_axis_tdata[45:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            start1_reg   <= in_start;
            end1_reg     <= in_end;
            // The packed order year, month, day makes one compare lexicographic.
            earlier2_reg <= (start1_reg < end1_reg);
            earlier3_reg <= earlier2_reg;
            count_reg    <= count_next;
            flag_reg     <= flag_next;
        end
    end

    gdd_day_number u_start_num (
        .clk     (clk),
        .en      (adv),
        .date    (start1_reg),
        .day_num (start_num)
    );

    gdd_day_number u_end_num (
        .clk     (clk),
        .en      (adv),
        .date    (end1_reg),
        .day_num (end_num)
    );

    always_comb
    begin
        diff = {1'b0, end_num} - {1'b0, start_num};
        if (!earlier3_reg)
        begin
            count_next = '0;
            flag_next  = 1'b1;
        end
        else
        begin
            // Invalid day fields can make an earlier date give a negative difference.
            count_next = diff[22] ? '0 : diff[21:0];
            flag_next  = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, count_reg};
    assign m_axis_tuser  = flag_reg;

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("not_earlier result carries a nonzero count");

    // The widest span runs from day zero of year zero to the last field codes of year 9999.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 24'd3652456)
        else $error("day count beyond the range of clamped years");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && adv |=> m_axis_tvalid)
        else $error("word in the last stage did not reach the output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v1_reg) && $stable(v2_reg) && $stable(v3_reg))
        else $error("pipeline moved during a stall");

endmodule

>>> tb/gdd_span_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the date difference core. Every accepted input word
// yields one expected day count, and every accepted output word is compared with
// the oldest one still waiting.
module gdd_span_checker
    import gdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          mismatches,
    output int          waiting,
    output int          results_seen,
    output int          flagged_seen
);

    localparam longint COUNT_CEILING = 64'd4194303;

    typedef struct {
        logic [21:0] day_count;
        logic        not_earlier;
        logic [47:0] word;
    } span_t;

    span_t expected_spans[$];

    function automatic int saturate_year(logic [13:0] y);
        return (y > MAX_YEAR) ? int'(MAX_YEAR) : int'(y);
    endfunction

    function automatic bit leap_year(int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    // Days in all years from year zero up to, but not including, y.
    function automatic longint days_to_year(int y);
        longint n;
        n = 365 * longint'(y);
        return n + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    // Month zero has nothing before it; any month past twelve has the full year.
    function automatic longint ordinal_day(int y, int m, int d);
        longint n;
        n = d;
        for (int k = 1; k < m && k <= 12; k++)
            n += (k == 2) ? 28 : ((k == 4 || k == 6 || k == 9 || k == 11) ? 30 : 31);
        if (m >= 3 && leap_year(y))
            n += 1;
        return n;
    endfunction

    function automatic span_t predict_span(logic [47:0] word);
        date_t  from_date;
        date_t  to_date;
        int     sy;
        int     ey;
        bit     earlier;
        longint diff;
        span_t  r;
        from_date = word[22:0];
        to_date   = word[45:23];
        sy = saturate_year(from_date.year);
        ey = saturate_year(to_date.year);
        if (sy != ey)
            earlier = sy < ey;
        else if (from_date.month != to_date.month)
            earlier = from_date.month < to_date.month;
        else
            earlier = from_date.day < to_date.day;
        r.word = word;
        if (!earlier) begin
            r.day_count   = '0;
            r.not_earlier = 1'b1;
        end
        else begin
            diff = days_to_year(ey) + ordinal_day(ey, to_date.month, to_date.day)
                 - days_to_year(sy) - ordinal_day(sy, from_date.month, from_date.day);
            if (diff < 0)
                diff = 0;
            if (diff > COUNT_CEILING)
                diff = COUNT_CEILING;
            r.day_count   = diff[21:0];
            r.not_earlier = 1'b0;
        end
        return r;
    endfunction

    initial
    begin
        mismatches   = 0;
        waiting      = 0;
        results_seen = 0;
        flagged_seen = 0;
    end

    always @(posedge clk)
    begin
        span_t want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser)
                    flagged_seen++;
                if (expected_spans.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word count=%0d flag=%0b",
                                 $time, m_axis_tdata[21:0], m_axis_tuser);
                    mismatches++;
                end
                else begin
                    want = expected_spans.pop_front();
                    if (m_axis_tdata[21:0] !== want.day_count ||
                        m_axis_tuser !== want.not_earlier) begin
                        if (mismatches < 10)
                            $display("%0t: input %h: expected count=%0d flag=%0b, got count=%0d flag=%0b",
                                     $time, want.word, want.day_count, want.not_earlier,
                                     m_axis_tdata[21:0], m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_spans.push_back(predict_span(s_axis_tdata));
            waiting = expected_spans.size();
        end
    end

endmodule

>>> tb/tb_gregorian_date_difference_core.sv
`timescale 1ns / 1ps

module tb_gregorian_date_difference_core
    import gdd_pkg::*;
();

    localparam int RANDOM_WORDS  = 930;
    localparam int STALL_CYCLES  = 150;
    localparam int STALL_AT      = 300;
    localparam int BURST_FROM    = 520;
    localparam int BURST_TO      = 640;
    localparam int DRAIN_CYCLES  = 12;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    int  mismatches;
    int  waiting;
    int  results_seen;
    int  flagged_seen;
    int  words_sent = 0;
    int  directed_words = 0;
    logic no_idle;

    // For a stretch in the middle neither side idles at all.
    assign no_idle = (words_sent >= BURST_FROM) && (words_sent < BURST_TO);

    gregorian_date_difference_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gdd_span_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .waiting       (waiting),
        .results_seen  (results_seen),
        .flagged_seen  (flagged_seen)
    );

    always #5 clk = ~clk;

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int month_length(int m, int y);
        if (m == 2)
            return ((y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0))) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic date_t valid_date();
        date_t d;
        d.year  = 14'($urandom_range(1, 9999));
        d.month = 4'($urandom_range(1, 12));
        d.day   = 5'($urandom_range(1, month_length(d.month, d.year)));
        return d;
    endfunction

    // Most pairs are real calendar dates, many of them close together so that the
    // month and day comparisons decide; the rest carry arbitrary field bits.
    function automatic logic [47:0] random_pair();
        date_t       a;
        date_t       b;
        logic [31:0] r;
        int          kind;
        kind = $urandom_range(0, 99);
        a = valid_date();
        b = valid_date();
        if (kind < 55)
        begin
            if ($urandom_range(0, 1))
            begin
                b.year = (a.year > 14'd9995) ? a.year : a.year + 14'($urandom_range(0, 3));
                b.day  = 5'($urandom_range(1, month_length(b.month, b.year)));
            end
        end
        else if (kind < 75)
        begin
            b.year = a.year;
            if ($urandom_range(0, 1))
                b.month = a.month;
            b.day = 5'($urandom_range(1, month_length(b.month, b.year)));
        end
        else
        begin
            r = $urandom;
            a = r[22:0];
            r = $urandom;
            b = r[22:0];
        end
        return {2'b00, b, a};
    endfunction

    // Called at a falling edge; returns at a falling edge after the word went in
    // and any idle gap that follows it.
    task automatic send_word(input logic [47:0] word);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        words_sent++;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_dates(input int sd, input int sm, input int sy,
                              input int ed, input int em, input int ey);
        date_t from_date;
        date_t to_date;
        from_date.day   = 5'(sd);
        from_date.month = 4'(sm);
        from_date.year  = 14'(sy);
        to_date.day     = 5'(ed);
        to_date.month   = 4'(em);
        to_date.year    = 14'(ey);
        directed_words++;
        send_word({2'b00, to_date, from_date});
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_dates( 1,  1,     1, 31, 12,  9999);   // widest valid span
        send_dates(31, 12,  9999,  1,  1,     1);   // start after end
        send_dates(15,  6,  2024, 15,  6,  2024);   // identical dates
        send_dates( 1,  1,  2000,  1,  1,  2001);   // leap year divisible by 400
        send_dates( 1,  1,  1900,  1,  1,  1901);   // century year, not leap
        send_dates(28,  2,  2024,  1,  3,  2024);
        send_dates(28,  2,  2100,  1,  3,  2100);
        send_dates(31,  5,  2023,  1,  6,  2023);   // month decides
        send_dates(10,  7,  2023,  9,  7,  2023);   // day decides, start later
        send_dates( 1,  1, 16383,  1,  1,  9999);   // equal once the year saturates
        send_dates( 1,  1,  9998,  1,  1, 10000);
        send_dates( 1,  1,     0,  1,  1,     1);   // year zero counts as leap
        send_dates( 5,  0,  2020,  5,  1,  2020);   // month zero
        send_dates( 1, 12,  2020,  1, 13,  2020);   // month thirteen
        send_dates( 0, 15,  2019, 31, 15,  2019);   // largest month code, day zero
        send_dates( 0,  3,  2021, 31,  2,  2021);   // day past the end of February
        send_dates(31,  0,  2020,  0,  1,  2020);   // earlier yet a negative count
        send_dates(31,  1,  2020,  0,  2,  2020);   // earlier with a zero count
        send_dates(31, 15, 16383,  0,  0,     0);   // all fields at their maxima
        send_dates( 0,  0,     0, 31, 15, 16383);
        send_dates(29,  2,  2000, 29,  2,  2400);

        for (int i = 0; i < RANDOM_WORDS; i++)
            send_word(random_pair());
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;

        wait (waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d date pairs: %0d directed corner cases, the rest random.",
                 words_sent, directed_words);
        $display("Checked %0d results (%0d flagged not earlier), with a %0d-cycle hold-off.",
                 results_seen, flagged_seen, STALL_CYCLES);
        if (mismatches == 0 && waiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Output side: random back-pressure, one long hold-off to fill the pipeline.
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && words_sent >= STALL_AT)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
            end
            else if (no_idle)
            begin
                m_axis_tready <= 1'b1;
                @(negedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                m_axis_tready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Run timed out with %0d results still outstanding.", waiting);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
